// ----- rtl/adsr_pkg.sv -----
`default_nettype none

package adsr_pkg;

	localparam int LEVEL_W   = 31;
	localparam int FACTOR_W  = 17;
	localparam int STEPS_W   = 24;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 31;

	localparam logic [LEVEL_W-1:0] LEVEL_MAX = {LEVEL_W{1'b1}};
	localparam logic [STEPS_W-1:0] DIVIDER_RESET = STEPS_W'(479);

	typedef enum logic [2:0] {
		PH_ATTACK  = 3'd0,
		PH_DECAY   = 3'd1,
		PH_SUSTAIN = 3'd2,
		PH_RELEASE = 3'd3,
		PH_IDLE    = 3'd4
	} phase_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ATTACK_INCREMENT = 3'd0,
		REG_DECAY_FACTOR     = 3'd1,
		REG_RELEASE_FACTOR   = 3'd2,
		REG_PEAK_LEVEL       = 3'd3,
		REG_SUSTAIN_LEVEL    = 3'd4,
		REG_RELEASE_FLOOR    = 3'd5,
		REG_SUSTAIN_STEPS    = 3'd6,
		REG_TICK_DIVIDER     = 3'd7
	} cfg_idx_t;

	typedef struct packed {
		logic [LEVEL_W-1:0]  attack_increment;
		logic [FACTOR_W-1:0] decay_factor;
		logic [FACTOR_W-1:0] release_factor;
		logic [LEVEL_W-1:0]  peak_level;
		logic [LEVEL_W-1:0]  sustain_level;
		logic [LEVEL_W-1:0]  release_floor;
		logic [STEPS_W-1:0]  sustain_steps;
		logic [STEPS_W-1:0]  tick_divider;
	} cfg_t;

endpackage

`default_nettype wire

// ----- rtl/adsr_cfg_regs.sv -----
`default_nettype none

module adsr_cfg_regs
	import adsr_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  wr_en,
	input  wire logic [CFG_IDX_W-1:0]  wr_index,
	input  wire logic [CFG_DATA_W-1:0] wr_data,
	output cfg_t                       cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.attack_increment <= '0;
			cfg_q.decay_factor     <= '0;
			cfg_q.release_factor   <= '0;
			cfg_q.peak_level       <= '0;
			cfg_q.sustain_level    <= '0;
			cfg_q.release_floor    <= '0;
			cfg_q.sustain_steps    <= '0;
			cfg_q.tick_divider     <= DIVIDER_RESET;
		end else if (wr_en) begin
			case (cfg_idx_t'(wr_index))
				REG_ATTACK_INCREMENT: cfg_q.attack_increment <= wr_data[LEVEL_W-1:0];
				REG_DECAY_FACTOR:     cfg_q.decay_factor     <= wr_data[FACTOR_W-1:0];
				REG_RELEASE_FACTOR:   cfg_q.release_factor   <= wr_data[FACTOR_W-1:0];
				REG_PEAK_LEVEL:       cfg_q.peak_level       <= wr_data[LEVEL_W-1:0];
				REG_SUSTAIN_LEVEL:    cfg_q.sustain_level    <= wr_data[LEVEL_W-1:0];
				REG_RELEASE_FLOOR:    cfg_q.release_floor    <= wr_data[LEVEL_W-1:0];
				REG_SUSTAIN_STEPS:    cfg_q.sustain_steps    <= wr_data[STEPS_W-1:0];
				REG_TICK_DIVIDER:     cfg_q.tick_divider     <= wr_data[STEPS_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ----- rtl/adsr_step.sv -----
`default_nettype none

module adsr_step
	import adsr_pkg::*;
#(
	parameter int COUNT_WIDTH = 24
) (
	input  wire cfg_t                    cfg,
	input  wire logic                    command,
	input  wire logic [2:0]              new_phase,
	input  wire logic [LEVEL_W-1:0]      volume,
	input  wire phase_t                  phase,
	input  wire logic [COUNT_WIDTH-1:0]  prescale,
	input  wire logic [COUNT_WIDTH-1:0]  hold,
	output logic      [LEVEL_W-1:0]      volume_next,
	output phase_t                       phase_next,
	output logic      [COUNT_WIDTH-1:0]  prescale_next,
	output logic      [COUNT_WIDTH-1:0]  hold_next
);

	localparam int CMP_W  = (COUNT_WIDTH > STEPS_W) ? COUNT_WIDTH : STEPS_W;
	localparam int PROD_W = LEVEL_W + FACTOR_W;

	logic [CMP_W-1:0]       prescale_ext;
	logic [CMP_W-1:0]       divider_ext;
	logic [CMP_W-1:0]       hold_inc_ext;
	logic [CMP_W-1:0]       steps_ext;
	logic [COUNT_WIDTH-1:0] hold_inc;
	logic [LEVEL_W:0]       attack_sum;
	logic [LEVEL_W-1:0]     attack_sat;
	logic [FACTOR_W-1:0]    factor;
	logic [PROD_W-1:0]      product;
	logic [LEVEL_W-1:0]     scaled;
	logic                   step_due;

	assign prescale_ext = CMP_W'(prescale);
	assign divider_ext  = CMP_W'(cfg.tick_divider);
	assign step_due     = prescale_ext >= divider_ext;

	assign hold_inc     = hold + COUNT_WIDTH'(1);
	assign hold_inc_ext = CMP_W'(hold_inc);
	assign steps_ext    = CMP_W'(cfg.sustain_steps);

	assign attack_sum = {1'b0, volume} + {1'b0, cfg.attack_increment};
	assign attack_sat = attack_sum[LEVEL_W] ? LEVEL_MAX : attack_sum[LEVEL_W-1:0];

	// Decay and release share the one multiplier; the Q16 shift keeps the top bits,
	// and any bit above the level width means the product saturates.
	assign factor  = (phase == PH_DECAY) ? cfg.decay_factor : cfg.release_factor;
	assign product = PROD_W'(volume) * PROD_W'(factor);
	assign scaled  = product[PROD_W-1] ? LEVEL_MAX : product[PROD_W-2:16];

	always_comb begin
		volume_next   = volume;
		phase_next    = phase;
		prescale_next = prescale + COUNT_WIDTH'(1);
		hold_next     = hold;
		if (command) begin
			phase_next    = (new_phase > 3'(PH_IDLE)) ? PH_IDLE : phase_t'(new_phase);
			hold_next     = '0;
			prescale_next = '0;
		end else if (step_due) begin
			prescale_next = '0;
			case (phase)
				PH_ATTACK: begin
					if (attack_sat >= cfg.peak_level) begin
						volume_next = cfg.peak_level;
						phase_next  = PH_DECAY;
					end else begin
						volume_next = attack_sat;
					end
				end
				PH_DECAY: begin
					if (scaled <= cfg.sustain_level) begin
						volume_next = cfg.sustain_level;
						phase_next  = PH_SUSTAIN;
					end else begin
						volume_next = scaled;
					end
				end
				PH_SUSTAIN: begin
					if (hold_inc_ext >= steps_ext) begin
						hold_next  = '0;
						phase_next = PH_RELEASE;
					end else begin
						hold_next = hold_inc;
					end
				end
				PH_RELEASE: begin
					volume_next = scaled;
					if (scaled <= cfg.release_floor) begin
						phase_next = PH_IDLE;
					end
				end
				default: begin
					volume_next = '0;
					phase_next  = PH_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- rtl/adsr_envelope_generator.sv -----
// Channel   Direction  Handshake                  Payload
// item      in         item_valid / item_stall    command, new_phase
// result    out        result_valid / result_stall level, phase
// cfg       in         cfg_valid / cfg_ready      cfg_index, cfg_data
//
// Every accepted item gives one result, via the item register and then the result
// register; one item per cycle is sustained while the result side does not stall.
// The envelope step (one add or one 31x17 multiply, then a compare) sits between
// the item register and the result register, which also holds the envelope state.
// Reset puts the envelope in idle at level zero and loads the register defaults.
// A stalled result holds; item_stall rises only while the item register is full
// and the result register is full and stalled. Configuration writes are always taken.
`default_nettype none

module adsr_envelope_generator
	import adsr_pkg::*;
#(
	parameter int COUNT_WIDTH = 24
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  item_valid,
	output logic                       item_stall,
	input  wire logic                  command,
	input  wire logic [2:0]            new_phase,
	output logic                       result_valid,
	input  wire logic                  result_stall,
	output logic      [LEVEL_W-1:0]    level,
	output logic      [2:0]            phase,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t                   cfg;
	logic                   valid_s1;
	logic                   command_s1;
	logic [2:0]             new_phase_s1;
	logic                   advance;
	logic [LEVEL_W-1:0]     volume_q;
	phase_t                 phase_q;
	logic [COUNT_WIDTH-1:0] prescale_q;
	logic [COUNT_WIDTH-1:0] hold_q;
	logic [LEVEL_W-1:0]     volume_next;
	phase_t                 phase_next;
	logic [COUNT_WIDTH-1:0] prescale_next;
	logic [COUNT_WIDTH-1:0] hold_next;
	logic                   result_valid_q;

	assign cfg_ready = 1'b1;

	adsr_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// The buffered beat moves on whenever the result register is empty or drains.
	assign advance    = valid_s1 && (!result_valid_q || !result_stall);
	assign item_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			command_s1   <= command;
			new_phase_s1 <= new_phase;
		end
	end

	adsr_step #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_step (
		.cfg           (cfg),
		.command       (command_s1),
		.new_phase     (new_phase_s1),
		.volume        (volume_q),
		.phase         (phase_q),
		.prescale      (prescale_q),
		.hold          (hold_q),
		.volume_next   (volume_next),
		.phase_next    (phase_next),
		.prescale_next (prescale_next),
		.hold_next     (hold_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			volume_q       <= '0;
			phase_q        <= PH_IDLE;
			prescale_q     <= '0;
			hold_q         <= '0;
			result_valid_q <= 1'b0;
		end else if (advance) begin
			volume_q       <= volume_next;
			phase_q        <= phase_next;
			prescale_q     <= prescale_next;
			hold_q         <= hold_next;
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	assign result_valid = result_valid_q;
	assign level        = volume_q;
	assign phase        = 3'(phase_q);

endmodule

`default_nettype wire

// ----- rtl/adsr_checker.sv -----
`default_nettype none

module adsr_checker
	import adsr_pkg::*;
(
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               item_valid,
	input wire logic               item_stall,
	input wire logic               result_valid,
	input wire logic               result_stall,
	input wire logic [LEVEL_W-1:0] level,
	input wire logic [2:0]         phase,
	input wire logic               cfg_ready
);

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(level) && $stable(phase))
		else $error("stalled result beat changed");

	a_phase_legal: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> phase <= 3'(PH_IDLE))
		else $error("result phase code out of range");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> result_valid && result_stall)
		else $error("item side stalled while the result side is free");

	a_result_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(item_valid && !item_stall, 2))
		else $error("result beat without an item beat two cycles earlier");

	a_cfg_open: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("configuration port refused a write");

endmodule

bind adsr_envelope_generator adsr_checker u_adsr_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_stall   (item_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.level        (level),
	.phase        (phase),
	.cfg_ready    (cfg_ready)
);

`default_nettype wire
